@@ rtl/crsa_pkg.sv @@
package crsa_pkg;

    // default sizes of the group map and the longest run
    localparam int MAP_GROUPS_DEF = 4096;
    localparam int MAX_RUN_DEF    = 64;

    // eight sectors per group
    localparam int SECTOR_SHIFT = 3;

    // configuration register file
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START_SECTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_GROUP_COUNT  = 2'd2;

    localparam logic [6:0]  RUN_LENGTH_RST  = 7'd4;
    localparam logic [31:0] DATA_START_RST  = 32'd0;
    localparam logic [12:0] GROUP_COUNT_RST = 13'd4096;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [6:0]  run_length;
        logic [31:0] data_start_sector;
        logic [12:0] data_group_count;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] first_sector;
    } t_result;

endpackage

@@ rtl/crsa_req_if.sv @@
interface crsa_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] start_sector;

    modport source (output valid, output kind, output start_sector, input ready);
    modport sink (input valid, input kind, input start_sector, output ready);
endinterface

@@ rtl/crsa_rsp_if.sv @@
interface crsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] first_sector;

    modport source (output valid, output status, output first_sector, input ready);
    modport sink (input valid, input status, input first_sector, output ready);
endinterface

@@ rtl/contiguous_run_sector_allocator.sv @@
// first-fit run allocator over a bitmap with one used/free bit per group of
// eight data sectors. an allocate transfer (kind 0) scans the map from group 0
// upward, one group per cycle through the map memory's read port, for the
// first run_length free groups inside the data area, marks them used one per
// cycle and returns data_start_sector + 8 * group; with no room the status is
// no space. a free transfer (kind 1) clears run_length marks from the group
// holding start_sector, clipped at the end of the data area; a sector outside
// the data area gives a range status and changes nothing. one item is worked at
// a time. after reset the map is swept clear, one group per cycle, so no request
// is taken until the sweep is done. configuration is written through a simple
// write port (index 0 run_length, 1 data_start_sector, 2 data_group_count) while
// no request is in flight, a rule for the user that the block does not enforce.
// results sit in an output register so the next request can be taken while a
// response waits.
module contiguous_run_sector_allocator #(
    parameter int MAP_GROUPS = crsa_pkg::MAP_GROUPS_DEF,
    parameter int MAX_RUN    = crsa_pkg::MAX_RUN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [crsa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [crsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    crsa_req_if.sink                        i_req,
    crsa_rsp_if.source                      o_rsp
);

    localparam int GW = $clog2(MAP_GROUPS);

    // configuration registers
    crsa_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_length        <= crsa_pkg::RUN_LENGTH_RST;
            r_cfg.data_start_sector <= crsa_pkg::DATA_START_RST;
            r_cfg.data_group_count  <= crsa_pkg::GROUP_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                crsa_pkg::CFG_RUN_LENGTH:        r_cfg.run_length <= i_cfg_data[6:0];
                crsa_pkg::CFG_DATA_START_SECTOR: r_cfg.data_start_sector <= i_cfg_data;
                crsa_pkg::CFG_DATA_GROUP_COUNT:  r_cfg.data_group_count <= i_cfg_data[12:0];
                default: begin
                    // writes to unmapped indexes are dropped
                end
            endcase
        end
    end

    // map memory ports
    logic          w_rd_en;
    logic [GW-1:0] w_rd_addr;
    logic          w_rd_data;
    logic          w_wr_en;
    logic [GW-1:0] w_wr_addr;
    logic          w_wr_data;

    crsa_pkg::t_result w_result;
    logic              w_take;

    crsa_map_ram #(
        .DEPTH (MAP_GROUPS)
    ) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    crsa_ctrl #(
        .MAP_GROUPS (MAP_GROUPS),
        .MAX_RUN    (MAX_RUN)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .req           (i_req),
        .o_result      (w_result),
        .i_result_take (w_take),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data)
    );

    // output register: loads when empty or when the held response transfers
    logic              r_out_valid;
    crsa_pkg::t_status r_out_status;
    logic [31:0]       r_out_first;
    logic              w_space;

    assign w_space = !r_out_valid || o_rsp.ready;
    assign w_take  = w_result.valid && w_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_space) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_status <= w_result.status;
            r_out_first  <= w_result.first_sector;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.first_sector = r_out_first;

endmodule

@@ rtl/crsa_map_ram.sv @@
module crsa_map_ram #(
    parameter int DEPTH = crsa_pkg::MAP_GROUPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic                     o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic                     i_wr_data
);

    logic r_mem [DEPTH];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/crsa_ctrl.sv @@
module crsa_ctrl #(
    parameter int MAP_GROUPS = crsa_pkg::MAP_GROUPS_DEF,
    parameter int MAX_RUN    = crsa_pkg::MAX_RUN_DEF,
    localparam int GW        = $clog2(MAP_GROUPS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crsa_pkg::t_cfg    i_cfg,
    crsa_req_if.sink          req,
    output crsa_pkg::t_result o_result,
    input  logic              i_result_take,
    output logic              o_rd_en,
    output logic [GW-1:0]     o_rd_addr,
    input  logic              i_rd_data,
    output logic              o_wr_en,
    output logic [GW-1:0]     o_wr_addr,
    output logic              o_wr_data
);

    localparam int GCW = $clog2(MAP_GROUPS + 1);
    localparam int LW  = $clog2(MAX_RUN + 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FCHK  = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [GCW-1:0]       r_addr, n_addr;
    logic                 r_pend, n_pend;
    logic [GW-1:0]        r_pend_g, n_pend_g;
    logic [LW-1:0]        r_run, n_run;
    logic [LW-1:0]        r_cnt, n_cnt;
    logic                 r_wbit, n_wbit;
    logic [31:0]          r_sector, n_sector;
    crsa_pkg::t_status    r_status, n_status;
    logic [31:0]          r_first, n_first;

    logic [LW-1:0]  w_len;
    logic [GCW-1:0] w_groups;
    logic           w_issue;
    logic [LW-1:0]  w_run_inc;
    logic [31:0]    w_base_full;
    logic [GW-1:0]  w_base;
    logic [31:0]    w_diff;
    logic [28:0]    w_grp;
    logic [31:0]    w_room;

    // effective run length and group count
    always_comb begin
        if (i_cfg.run_length == 7'd0) begin
            w_len = LW'(1);
        end else if (32'(i_cfg.run_length) > 32'(MAX_RUN)) begin
            w_len = LW'(MAX_RUN);
        end else begin
            w_len = LW'(i_cfg.run_length);
        end
        if (32'(i_cfg.data_group_count) > 32'(MAP_GROUPS)) begin
            w_groups = GCW'(MAP_GROUPS);
        end else begin
            w_groups = GCW'(i_cfg.data_group_count);
        end
    end

    assign w_issue     = (r_addr < w_groups);
    assign w_run_inc   = LW'(r_run + 1'b1);
    assign w_base_full = 32'(r_pend_g) + 32'd1 - 32'(w_len);
    assign w_base      = w_base_full[GW-1:0];
    assign w_diff      = r_sector - i_cfg.data_start_sector;
    assign w_grp       = w_diff[31:crsa_pkg::SECTOR_SHIFT];
    assign w_room      = 32'(w_groups) - 32'(w_grp);

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_pend   = r_pend;
        n_pend_g = r_pend_g;
        n_run    = r_run;
        n_cnt    = r_cnt;
        n_wbit   = r_wbit;
        n_sector = r_sector;
        n_status = r_status;
        n_first  = r_first;

        unique case (r_state)
            S_CLEAR: begin
                n_addr = GCW'(r_addr + 1'b1);
                if (r_addr == GCW'(MAP_GROUPS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req.valid) begin
                    if (req.kind == crsa_pkg::KIND_ALLOC) begin
                        n_addr  = '0;
                        n_pend  = 1'b0;
                        n_run   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_sector = req.start_sector;
                        n_state  = S_FCHK;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read while the previous group is judged
                if (w_issue) begin
                    n_addr   = GCW'(r_addr + 1'b1);
                    n_pend   = 1'b1;
                    n_pend_g = r_addr[GW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (i_rd_data) begin
                        n_run = '0;
                    end else if (w_run_inc == w_len) begin
                        n_addr   = GCW'(w_base);
                        n_cnt    = w_len;
                        n_wbit   = 1'b1;
                        n_status = crsa_pkg::ST_DONE;
                        n_first  = i_cfg.data_start_sector
                                 + (32'(w_base) << crsa_pkg::SECTOR_SHIFT);
                        n_state  = S_WRITE;
                    end else begin
                        n_run = w_run_inc;
                    end
                end else if (!w_issue) begin
                    n_status = crsa_pkg::ST_NOSPACE;
                    n_first  = '0;
                    n_state  = S_DONE;
                end
            end
            S_FCHK: begin
                n_first = '0;
                if (r_sector < i_cfg.data_start_sector
                        || 32'(w_grp) >= 32'(w_groups)) begin
                    n_status = crsa_pkg::ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    n_status = crsa_pkg::ST_DONE;
                    n_addr   = GCW'(w_grp);
                    n_wbit   = 1'b0;
                    // clip the run at the end of the data area
                    n_cnt    = (w_room < 32'(w_len)) ? LW'(w_room) : w_len;
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                n_addr = GCW'(r_addr + 1'b1);
                n_cnt  = LW'(r_cnt - 1'b1);
                if (r_cnt == LW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_result_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_g <= n_pend_g;
        r_run    <= n_run;
        r_cnt    <= n_cnt;
        r_wbit   <= n_wbit;
        r_sector <= n_sector;
        r_status <= n_status;
        r_first  <= n_first;
    end

    assign req.ready = (r_state == S_IDLE);

    assign o_rd_en   = (r_state == S_SCAN) && w_issue;
    assign o_rd_addr = r_addr[GW-1:0];
    assign o_wr_en   = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign o_wr_addr = r_addr[GW-1:0];
    assign o_wr_data = (r_state == S_WRITE) ? r_wbit : 1'b0;

    assign o_result.valid        = (r_state == S_DONE);
    assign o_result.status       = r_status;
    assign o_result.first_sector = r_first;

endmodule
